[design/tri3d_pkg.sv]
// tri3d_pkg: shared constants for the 3d triangle doubled-area block
// no dependencies; imported by the top level
package tri3d_pkg;

    // number of vertex coordinates in one input word
    localparam int VERTEX_FIELDS = 9;

    // width of the doubled-area result field
    localparam int OUT_W = 34;

    // largest result value, used for saturation
    localparam logic [OUT_W-1:0] OUT_MAX = '1;

endpackage

[design/triangle_area_3d_top.sv]
// triangle_area_3d_top: doubled area of a 3d triangle via cross product and integer sqrt
// depends on tri3d_pkg and tri3d_sqrt
//
//  channel   | direction | tdata fields (low bit up)                   | tuser/tlast
//  ----------+-----------+---------------------------------------------+------------
//  s_axis    | in        | a_x a_y a_z b_x b_y b_z c_x c_y c_z         | none
//  m_axis    | out       | double_area (34 bits), zero padded          | none
//
// one word accepted per cycle while the output is not stalled; after the edge, product, cross,
// square and sum stages, the square root pipeline resolves one root bit per stage.
// reset clears the valid bits only; the pipeline is empty afterwards.
// a stalled output holds the whole pipeline; s_axis tready drops only while a result
// waits in the output stage and m_axis tready is low.
module triangle_area_3d_top
    import tri3d_pkg::*;
#(
    parameter int COORD_BITS = 16
) (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  logic                                        i_s_axis_tvalid,
    output logic                                        o_s_axis_tready,
    // a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z, then zero pad
    input  logic [((VERTEX_FIELDS*COORD_BITS+7)/8)*8-1:0] i_s_axis_tdata,
    output logic                                        o_m_axis_tvalid,
    input  logic                                        i_m_axis_tready,
    // double_area, then zero pad
    output logic [((OUT_W+7)/8)*8-1:0]                  o_m_axis_tdata
);

    localparam int C      = COORD_BITS;
    localparam int D      = C + 1;          // edge component
    localparam int P      = 2 * D;          // product
    localparam int N      = P + 1;          // cross component
    localparam int M      = P;              // cross magnitude
    localparam int S      = 4 * D;          // squares and their sum
    localparam int ROOT_W = 2 * D;
    localparam int EXT_W  = (ROOT_W > OUT_W) ? ROOT_W : OUT_W;
    localparam int ODATA_W = ((OUT_W + 7) / 8) * 8;

    logic w_en;

    // coordinate fields
    logic signed [C-1:0] w_crd [VERTEX_FIELDS];

    always_comb begin
        for (int i = 0; i < VERTEX_FIELDS; i++) begin
            w_crd[i] = i_s_axis_tdata[i*C +: C];
        end
    end

    // whole pipeline moves unless the output word is stalled
    assign w_en            = !o_m_axis_tvalid || i_m_axis_tready;
    assign o_s_axis_tready = w_en;

    // stage 1: edge vectors u = b - a, v = c - a
    logic              r_v1;
    logic signed [D-1:0] r_ux, r_uy, r_uz, r_vx, r_vy, r_vz;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_ux <= D'(w_crd[3]) - D'(w_crd[0]);
            r_uy <= D'(w_crd[4]) - D'(w_crd[1]);
            r_uz <= D'(w_crd[5]) - D'(w_crd[2]);
            r_vx <= D'(w_crd[6]) - D'(w_crd[0]);
            r_vy <= D'(w_crd[7]) - D'(w_crd[1]);
            r_vz <= D'(w_crd[8]) - D'(w_crd[2]);
        end
    end

    // stage 2: six partial products of the cross product
    logic              r_v2;
    logic signed [P-1:0] r_p_uyvz, r_p_uzvy, r_p_uzvx, r_p_uxvz, r_p_uxvy, r_p_uyvx;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_p_uyvz <= P'(r_uy) * P'(r_vz);
            r_p_uzvy <= P'(r_uz) * P'(r_vy);
            r_p_uzvx <= P'(r_uz) * P'(r_vx);
            r_p_uxvz <= P'(r_ux) * P'(r_vz);
            r_p_uxvy <= P'(r_ux) * P'(r_vy);
            r_p_uyvx <= P'(r_uy) * P'(r_vx);
        end
    end

    // stage 3: cross components and their magnitudes
    logic signed [N-1:0] w_nx, w_ny, w_nz;
    logic              r_v3;
    logic [M-1:0]      r_mx, r_my, r_mz;

    assign w_nx = N'(r_p_uyvz) - N'(r_p_uzvy);
    assign w_ny = N'(r_p_uzvx) - N'(r_p_uxvz);
    assign w_nz = N'(r_p_uxvy) - N'(r_p_uyvx);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_mx <= w_nx[N-1] ? M'(-w_nx) : M'(w_nx);
            r_my <= w_ny[N-1] ? M'(-w_ny) : M'(w_ny);
            r_mz <= w_nz[N-1] ? M'(-w_nz) : M'(w_nz);
        end
    end

    // stage 4: squares
    logic         r_v4;
    logic [S-1:0] r_sx, r_sy, r_sz;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sx <= S'(r_mx) * S'(r_mx);
            r_sy <= S'(r_my) * S'(r_my);
            r_sz <= S'(r_mz) * S'(r_mz);
        end
    end

    // stage 5: squared length of the normal
    logic         r_v5;
    logic [S-1:0] r_sum;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sum <= r_sx + r_sy + r_sz;
        end
    end

    // valid bits of the front stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else if (w_en) begin
            r_v1 <= i_s_axis_tvalid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
        end
    end

    // square root pipeline; its last stage is the output register
    logic [ROOT_W-1:0] w_root;
    logic [S-1:0]      w_rem;

    tri3d_sqrt #(
        .ROOT_W (ROOT_W)
    ) u_sqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (w_en),
        .i_valid    (r_v5),
        .i_radicand (r_sum),
        .o_valid    (o_m_axis_tvalid),
        .o_root     (w_root),
        .o_rem      (w_rem)
    );

    // saturate to the result width
    logic [EXT_W-1:0] w_root_ext;
    logic             w_sat;
    logic [OUT_W-1:0] w_area;

    assign w_root_ext     = EXT_W'(w_root);
    assign w_sat          = (w_root_ext > EXT_W'(OUT_MAX));
    assign w_area         = w_sat ? OUT_MAX : OUT_W'(w_root_ext);
    assign o_m_axis_tdata = ODATA_W'(w_area);

`ifndef ASSERT_OFF
    // the cycle after reset the output stage is empty
    a_empty_after_reset: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_m_axis_tvalid)
        else $error("output valid right after reset");

    // input is refused only while a result waits
    a_refuse_only_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> (o_m_axis_tvalid && !i_m_axis_tready))
        else $error("input refused without a waiting result");

    // the final remainder is in range for a floor square root
    a_root_remainder: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (w_rem <= S'({w_root, 1'b0})))
        else $error("square root remainder out of range");
`endif

endmodule

[design/tri3d_sqrt.sv]
// tri3d_sqrt: pipelined floor integer square root, one root bit per stage
// stand-alone; instantiated by triangle_area_3d_top
module tri3d_sqrt #(
    parameter int ROOT_W = 34
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_valid,
    input  logic [2*ROOT_W-1:0]   i_radicand,
    output logic                  o_valid,
    output logic [ROOT_W-1:0]     o_root,
    output logic [2*ROOT_W-1:0]   o_rem
);

    localparam int RAD_W = 2 * ROOT_W;

    // stage registers; the stage inputs below take stage 0 from the ports
    logic             r_v   [1:ROOT_W];
    logic [RAD_W-1:0] r_rem [1:ROOT_W];
    logic [ROOT_W-1:0] r_q  [1:ROOT_W];

    logic             w_v   [0:ROOT_W-1];
    logic [RAD_W-1:0] w_rem [0:ROOT_W-1];
    logic [ROOT_W-1:0] w_q  [0:ROOT_W-1];

    genvar k;
    generate
        for (k = 0; k < ROOT_W; k++) begin : g_stage
            localparam int B = ROOT_W - 1 - k;

            logic [RAD_W-1:0] w_q_ext;
            logic [RAD_W-1:0] w_trial;
            logic             w_take;

            // stage input select
            if (k == 0) begin : g_first
                assign w_v[k]   = i_valid;
                assign w_rem[k] = i_radicand;
                assign w_q[k]   = '0;
            end else begin : g_next
                assign w_v[k]   = r_v[k];
                assign w_rem[k] = r_rem[k];
                assign w_q[k]   = r_q[k];
            end

            // trial subtrahend for root bit B: 2*q*2^B + 2^(2B)
            assign w_q_ext = RAD_W'(w_q[k]);
            assign w_trial = (w_q_ext << (B + 1)) | (RAD_W'(1) << (2 * B));
            assign w_take  = (w_rem[k] >= w_trial);

            // valid bit
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_v[k+1] <= 1'b0;
                end else if (i_en) begin
                    r_v[k+1] <= w_v[k];
                end
            end

            // remainder and partial root
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[k+1] <= w_take ? (w_rem[k] - w_trial) : w_rem[k];
                    r_q[k+1]   <= w_q[k] | (w_take ? (ROOT_W'(1) << B) : '0);
                end
            end
        end
    endgenerate

    assign o_valid = r_v[ROOT_W];
    assign o_root  = r_q[ROOT_W];
    assign o_rem   = r_rem[ROOT_W];

endmodule

[tb/sv/triangle_area_3d_monitor.sv]
`timescale 1ns / 1ps
// triangle_area_3d_monitor: watches both stream channels of triangle_area_3d_top
// predicts the doubled area of each accepted triangle and compares it in order; uses tri3d_pkg
module triangle_area_3d_monitor
    import tri3d_pkg::*;
#(
    parameter int COORD_BITS = 16,
    parameter int IN_W       = ((VERTEX_FIELDS*COORD_BITS+7)/8)*8,
    parameter int OUT_DW     = ((OUT_W+7)/8)*8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_axis_tvalid,
    input  logic              i_s_axis_tready,
    // a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z, then zero pad
    input  logic [IN_W-1:0]   i_s_axis_tdata,
    input  logic              i_m_axis_tvalid,
    input  logic              i_m_axis_tready,
    // double_area, then zero pad
    input  logic [OUT_DW-1:0] i_m_axis_tdata,
    output int                o_fail_count,
    output int                o_pending
);

    logic [OUT_W-1:0] expected_areas[$];
    logic [OUT_W-1:0] want;
    int               seen_results;

    // floor square root of the squared cross product length, saturated to the field
    function automatic logic [OUT_W-1:0] double_area_of(input logic [IN_W-1:0] word);
        logic signed [COORD_BITS-1:0] raw;
        logic signed [63:0]           v[VERTEX_FIELDS];
        logic signed [63:0]           ux, uy, uz, vx, vy, vz, nx, ny, nz;
        logic signed [127:0]          wx, wy, wz;
        logic [127:0]                 norm_sq;
        logic [63:0]                  root, trial;
        for (int k = 0; k < VERTEX_FIELDS; k++) begin
            raw  = word[k*COORD_BITS +: COORD_BITS];
            v[k] = raw;
        end
        // edge vectors from the first vertex
        ux = v[3] - v[0];
        uy = v[4] - v[1];
        uz = v[5] - v[2];
        vx = v[6] - v[0];
        vy = v[7] - v[1];
        vz = v[8] - v[2];
        nx = uy * vz - uz * vy;
        ny = uz * vx - ux * vz;
        nz = ux * vy - uy * vx;
        wx = nx;
        wy = ny;
        wz = nz;
        norm_sq = 128'(wx * wx) + 128'(wy * wy) + 128'(wz * wz);
        // bitwise floor root, the result stays well below 2^48
        root = '0;
        for (int b = 47; b >= 0; b--) begin
            trial = root | (64'd1 << b);
            if (128'(trial) * 128'(trial) <= norm_sq)
                root = trial;
        end
        if (root > 64'(OUT_MAX))
            root = 64'(OUT_MAX);
        return root[OUT_W-1:0];
    endfunction

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch on result %0d: %s", $realtime, seen_results, what);
        o_fail_count++;
    endtask

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        seen_results = 0;
    end

    // compare results first, then record new triangles
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                if (expected_areas.size() == 0) begin
                    report_mismatch($sformatf("word %0h with nothing outstanding",
                                              i_m_axis_tdata));
                end else begin
                    want = expected_areas.pop_front();
                    if (i_m_axis_tdata[OUT_W-1:0] !== want)
                        report_mismatch($sformatf("double_area %0d, want %0d",
                                                  i_m_axis_tdata[OUT_W-1:0], want));
                end
                seen_results++;
            end
            if (i_s_axis_tvalid && i_s_axis_tready)
                expected_areas.push_back(double_area_of(i_s_axis_tdata));
            o_pending = expected_areas.size();
        end
    end

endmodule

[tb/sv/triangle_area_3d_top_test.sv]
`timescale 1ns / 1ps
// triangle_area_3d_top_test: stimulus and verdict for triangle_area_3d_top
// depends on tri3d_pkg, the block and triangle_area_3d_monitor
module triangle_area_3d_top_test;
    import tri3d_pkg::*;

    localparam int COORD_BITS = 16;
    localparam int IN_W       = ((VERTEX_FIELDS*COORD_BITS+7)/8)*8;
    localparam int OUT_DW     = ((OUT_W+7)/8)*8;
    localparam int C_MAX      = (1 << (COORD_BITS-1)) - 1;
    localparam int C_MIN      = -(1 << (COORD_BITS-1));

    logic              i_clk;
    logic              i_rst_n;
    logic              i_s_axis_tvalid;
    logic              o_s_axis_tready;
    // a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z, then zero pad
    logic [IN_W-1:0]   i_s_axis_tdata;
    logic              o_m_axis_tvalid;
    logic              i_m_axis_tready;
    // double_area, then zero pad
    logic [OUT_DW-1:0] o_m_axis_tdata;

    int fail_count;
    int pending;
    int send_idle_pct;
    int recv_stall_pct;
    int hold_left;

    triangle_area_3d_top #(.COORD_BITS(COORD_BITS)) i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    triangle_area_3d_monitor #(.COORD_BITS(COORD_BITS)) i_monitor (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .i_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .i_m_axis_tdata  (o_m_axis_tdata),
        .o_fail_count    (fail_count),
        .o_pending       (pending)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #5_000_000;
        $display("simulation failed");
        $finish;
    end

    // receiver: random stalls plus one long hold-off
    initial begin
        i_m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                hold_left--;
                i_m_axis_tready <= 1'b0;
            end else begin
                i_m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    function automatic logic [IN_W-1:0] triangle_word(input int ax, ay, az,
                                                      input int bx, by, bz,
                                                      input int cx, cy, cz);
        logic [IN_W-1:0] word;
        word = '0;
        word[0*COORD_BITS +: COORD_BITS] = COORD_BITS'(ax);
        word[1*COORD_BITS +: COORD_BITS] = COORD_BITS'(ay);
        word[2*COORD_BITS +: COORD_BITS] = COORD_BITS'(az);
        word[3*COORD_BITS +: COORD_BITS] = COORD_BITS'(bx);
        word[4*COORD_BITS +: COORD_BITS] = COORD_BITS'(by);
        word[5*COORD_BITS +: COORD_BITS] = COORD_BITS'(bz);
        word[6*COORD_BITS +: COORD_BITS] = COORD_BITS'(cx);
        word[7*COORD_BITS +: COORD_BITS] = COORD_BITS'(cy);
        word[8*COORD_BITS +: COORD_BITS] = COORD_BITS'(cz);
        return word;
    endfunction

    function automatic int edge_coord();
        case ($urandom_range(6))
            0:       return C_MIN;
            1:       return C_MIN + 1;
            2:       return -1;
            3:       return 0;
            4:       return 1;
            5:       return C_MAX - 1;
            default: return C_MAX;
        endcase
    endfunction

    // mix of full range, small, extreme and collinear triangles
    function automatic logic [IN_W-1:0] random_triangle();
        int c[VERTEX_FIELDS];
        int kind, mult;
        int d[3];
        logic [IN_W-1:0] word;
        kind = $urandom_range(9);
        for (int k = 0; k < VERTEX_FIELDS; k++) begin
            if (kind <= 3)
                c[k] = int'($urandom());
            else if (kind <= 5)
                c[k] = $urandom_range(40) - 20;
            else
                c[k] = edge_coord();
        end
        if (kind >= 8) begin
            // third vertex on the line through the first two
            mult = $urandom_range(400) - 200;
            for (int k = 0; k < 3; k++) begin
                d[k]     = $urandom_range(200) - 100;
                c[k]     = $urandom_range(2*C_MAX) - C_MAX;
                c[3 + k] = c[k] + d[k];
                c[6 + k] = c[k] + mult * d[k];
            end
        end
        word = '0;
        for (int k = 0; k < VERTEX_FIELDS; k++)
            word[k*COORD_BITS +: COORD_BITS] = COORD_BITS'(c[k]);
        return word;
    endfunction

    // offer one word, holding it until the block takes it
    task automatic send_triangle(input logic [IN_W-1:0] word);
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= word;
        do @(posedge i_clk); while (!o_s_axis_tready);
        @(negedge i_clk);
    endtask

    task automatic drain_results();
        i_s_axis_tvalid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0)
            @(negedge i_clk);
    endtask

    task automatic random_phase(input int count, input int idle_pct, input int stall_pct);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (count) send_triangle(random_triangle());
    endtask

    // stimulus
    initial begin
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        send_idle_pct   = 0;
        recv_stall_pct  = 0;
        hold_left       = 0;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: extremes, degenerate and known areas
        send_triangle(triangle_word(0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_triangle(triangle_word(C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX,
                                    C_MAX, C_MAX, C_MAX));
        send_triangle(triangle_word(C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN,
                                    C_MIN, C_MIN, C_MIN));
        send_triangle(triangle_word(0, 0, 0, 1, 0, 0, 0, 1, 0));
        send_triangle(triangle_word(0, 0, 0, 1, 2, 3, 2, 4, 6));
        send_triangle(triangle_word(5, -7, 9, 5, -7, 9, 100, 200, -300));
        send_triangle(triangle_word(1, 2, 3, 40, 50, 60, 40, 50, 60));
        send_triangle(triangle_word(C_MIN, C_MIN, C_MIN, 0, 0, 0, C_MAX, C_MAX, C_MAX));
        send_triangle(triangle_word(C_MIN, C_MIN, C_MIN, C_MAX, C_MIN, C_MIN,
                                    C_MIN, C_MAX, C_MIN));
        send_triangle(triangle_word(C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MIN,
                                    C_MIN, C_MAX, C_MAX));
        send_triangle(triangle_word(C_MAX, C_MIN, C_MAX, C_MIN, C_MAX, C_MIN,
                                    C_MAX, C_MAX, C_MIN));
        send_triangle(triangle_word(C_MIN, C_MAX, C_MIN, C_MAX, C_MIN, C_MIN,
                                    C_MIN, C_MIN, C_MAX));
        send_triangle(triangle_word(C_MAX, C_MAX, C_MAX, C_MIN, C_MIN, C_MAX,
                                    C_MAX, C_MIN, C_MIN));
        send_triangle(triangle_word(-1, -1, -1, 0, 0, 0, 1, 1, 1));
        send_triangle(triangle_word(0, 0, 0, 3, 0, 0, 0, 4, 0));
        send_triangle(triangle_word(C_MIN, 0, C_MAX, C_MAX, 0, C_MIN, 0, C_MAX, 0));
        send_triangle(triangle_word(1, -1, 1, -1, 1, -1, C_MAX, C_MIN, 1));
        send_triangle(triangle_word(-1, -1, -1, -1, -1, -1, -1, -1, -1));

        // random traffic across idle and stall mixes
        random_phase(180, 0, 0);
        random_phase(170, 78, 0);
        random_phase(170, 0, 78);
        random_phase(170, 13, 13);

        // long receiver hold-off while the sender keeps offering words
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_left      = 300;
        repeat (80) send_triangle(random_triangle());

        // sender pauses until every result is back
        drain_results();
        random_phase(80, 13, 13);

        drain_results();
        repeat (60) @(posedge i_clk);
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

[filelist.f]
design/tri3d_pkg.sv
design/tri3d_sqrt.sv
design/triangle_area_3d_top.sv
tb/sv/triangle_area_3d_monitor.sv
tb/sv/triangle_area_3d_top_test.sv
